>>> rtl/bfra_pkg.sv
`default_nettype none
package bfra_pkg;

	localparam int MAX_BLOCKS = 64;
	localparam int POS_BITS = 24;
	localparam int IDX_BITS = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int STAMP_BITS = 32;

	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE = 2'd1;
	localparam logic [1:0] ACT_EXPAND = 2'd2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_FIT = 3'd1;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_EXHAUSTED = 3'd4;

	typedef struct packed {
		logic [1:0]          action;
		logic [POS_BITS-1:0] request_size;
		logic [POS_BITS-1:0] release_pos;
		logic [POS_BITS-1:0] new_capacity;
	} req_t;

	typedef struct packed {
		logic [2:0]          status;
		logic [POS_BITS-1:0] alloc_pos;
		logic [POS_BITS-1:0] largest_free;
		logic                has_allocations;
	} rsp_t;

	typedef struct packed {
		logic                  valid;
		logic [POS_BITS-1:0]   start;
		logic [POS_BITS-1:0]   length;
		logic                  is_free;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/best_fit_range_allocator.sv
// req_stall holds off further requests until the current result is loaded into the output register
// the descriptor ring makes three full rotations per request (search, right-neighbor search,
//   update and summary)
// a new request is taken while the previous result still waits at the output
// reset: all descriptors invalid, pool size and link stamp counter zero
`default_nettype none
module best_fit_range_allocator (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire bfra_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output bfra_pkg::rsp_t      rsp
);

	localparam int PB = bfra_pkg::POS_BITS;
	localparam int IB = bfra_pkg::IDX_BITS;
	localparam int SB = bfra_pkg::STAMP_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_RSCAN = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]     state_q;
	logic [IB-1:0]  cnt_q;
	bfra_pkg::req_t req_q;
	bfra_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	logic [SB-1:0]  counter_q;
	logic [PB-1:0]  cap_q;

	logic           spare_found_q, best_found_q, b_found_q, l_found_q, r_found_q;
	logic           tail_found_q, tail_free_q;
	logic [IB-1:0]  spare_q, best_q, b_q, l_q, r_q, tail_q;
	logic [PB-1:0]  best_len_q, best_start_q, len_b_q, len_r_q;
	logic [SB-1:0]  best_age_q;
	logic [2:0]     status_q;
	logic [PB-1:0]  largest_q;
	logic           used_q;

	bfra_pkg::entry_t ring [bfra_pkg::MAX_BLOCKS];
	bfra_pkg::entry_t head, upd;
	logic             shift, last;

	assign shift = (state_q == S_SCAN) || (state_q == S_RSCAN) || (state_q == S_APPLY);
	assign last = (cnt_q == IB'(bfra_pkg::MAX_BLOCKS - 1));
	assign head = ring[0];

	for (genvar i = 0; i < bfra_pkg::MAX_BLOCKS; i++) begin : g_cell
		bfra_pkg::entry_t nxt;
		if (i == bfra_pkg::MAX_BLOCKS - 1) begin : g_tail
			assign nxt = upd;
		end else begin : g_mid
			assign nxt = ring[i+1];
		end
		bfra_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift), .nxt(nxt), .cur(ring[i])
		);
	end

	// per-entry checks on the head of the ring
	logic [PB:0]   head_end;
	logic [SB-1:0] head_age;
	logic          alloc_cand, alloc_better;
	logic          exact, grow_tail, ok;
	logic [IB-1:0] keep;
	logic [PB-1:0] grow;
	logic [2:0]    status_c;

	assign head_end = {1'b0, head.start} + {1'b0, head.length};
	assign head_age = counter_q - head.stamp;
	assign alloc_cand = head.valid && head.is_free && (head.length >= req_q.request_size);
	assign alloc_better = !best_found_q || (head.length < best_len_q) ||
		((head.length == best_len_q) && (head_age < best_age_q));
	assign exact = (best_len_q == req_q.request_size);
	assign grow_tail = (cap_q != '0) && tail_found_q && tail_free_q;
	assign ok = (status_q == bfra_pkg::ST_OK);
	assign keep = l_found_q ? l_q : b_q;
	assign grow = req_q.new_capacity - cap_q;

	always_comb begin
		unique case (req_q.action)
			bfra_pkg::ACT_ALLOC: begin
				if (req_q.request_size == '0) status_c = bfra_pkg::ST_ZERO_SIZE;
				else if (!best_found_q) status_c = bfra_pkg::ST_NO_FIT;
				else if (exact) status_c = bfra_pkg::ST_OK;
				else if (!spare_found_q) status_c = bfra_pkg::ST_EXHAUSTED;
				else status_c = bfra_pkg::ST_OK;
			end
			bfra_pkg::ACT_FREE: begin
				status_c = b_found_q ? bfra_pkg::ST_OK : bfra_pkg::ST_INVALID;
			end
			bfra_pkg::ACT_EXPAND: begin
				if (req_q.new_capacity <= cap_q) status_c = bfra_pkg::ST_INVALID;
				else if (grow_tail) status_c = bfra_pkg::ST_OK;
				else if (!spare_found_q) status_c = bfra_pkg::ST_EXHAUSTED;
				else status_c = bfra_pkg::ST_OK;
			end
			default: status_c = bfra_pkg::ST_INVALID;
		endcase
	end

	// entry rewritten as it passes the head during the update rotation
	always_comb begin
		upd = head;
		if (state_q == S_APPLY && ok) begin
			case (req_q.action)
				bfra_pkg::ACT_ALLOC: begin
					if (exact) begin
						if (cnt_q == best_q) upd.is_free = 1'b0;
					end else if (cnt_q == spare_q) begin
						upd = '{valid: 1'b1, start: best_start_q, length: req_q.request_size,
							is_free: 1'b0, stamp: '0};
					end else if (cnt_q == best_q) begin
						upd.start = head.start + req_q.request_size;
						upd.length = head.length - req_q.request_size;
						upd.is_free = 1'b1;
						upd.stamp = counter_q;
					end
				end
				bfra_pkg::ACT_FREE: begin
					if (l_found_q && cnt_q == b_q) upd.valid = 1'b0;
					if (r_found_q && cnt_q == r_q) upd.valid = 1'b0;
					if (cnt_q == keep) begin
						upd.length = head.length + (l_found_q ? len_b_q : '0)
							+ (r_found_q ? len_r_q : '0);
						upd.is_free = 1'b1;
						upd.stamp = counter_q;
					end
				end
				bfra_pkg::ACT_EXPAND: begin
					if (grow_tail) begin
						if (cnt_q == tail_q) begin
							upd.length = head.length + grow;
							upd.is_free = 1'b1;
							upd.stamp = counter_q;
						end
					end else if (cnt_q == spare_q) begin
						upd = '{valid: 1'b1, start: cap_q, length: grow,
							is_free: 1'b1, stamp: counter_q};
					end
				end
				default: upd = head;
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			rsp_valid_q <= 1'b0;
			counter_q <= '0;
			cap_q <= '0;
		end else begin
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall))
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_SCAN;
						cnt_q <= '0;
					end
				end
				S_SCAN, S_RSCAN: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) begin
						state_q <= (state_q == S_SCAN) ? S_RSCAN : S_APPLY;
					end
				end
				S_APPLY: begin
					cnt_q <= last ? '0 : cnt_q + 1'b1;
					if (last) begin
						state_q <= S_DONE;
						if (ok && !(req_q.action == bfra_pkg::ACT_ALLOC && exact))
							counter_q <= counter_q + 1'b1;
						if (ok && req_q.action == bfra_pkg::ACT_EXPAND)
							cap_q <= req_q.new_capacity;
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				req_q <= req;
				spare_found_q <= 1'b0;
				best_found_q <= 1'b0;
				b_found_q <= 1'b0;
				l_found_q <= 1'b0;
				r_found_q <= 1'b0;
				tail_found_q <= 1'b0;
			end
			S_SCAN: begin
				if (!head.valid && !spare_found_q) begin
					spare_found_q <= 1'b1;
					spare_q <= cnt_q;
				end
				if (alloc_cand && alloc_better) begin
					best_found_q <= 1'b1;
					best_q <= cnt_q;
					best_len_q <= head.length;
					best_start_q <= head.start;
					best_age_q <= head_age;
				end
				if (head.valid && !head.is_free && head.start == req_q.release_pos
					&& !b_found_q) begin
					b_found_q <= 1'b1;
					b_q <= cnt_q;
					len_b_q <= head.length;
				end
				if (head.valid && head.is_free && head_end == {1'b0, req_q.release_pos}
					&& !l_found_q) begin
					l_found_q <= 1'b1;
					l_q <= cnt_q;
				end
				if (head.valid && head_end == {1'b0, cap_q}) begin
					tail_found_q <= 1'b1;
					tail_q <= cnt_q;
					tail_free_q <= head.is_free;
				end
			end
			S_RSCAN: begin
				// right neighbor starts where the released block ends
				if (b_found_q && head.valid && head.is_free && !r_found_q &&
					{1'b0, head.start} == {1'b0, req_q.release_pos} + {1'b0, len_b_q}) begin
					r_found_q <= 1'b1;
					r_q <= cnt_q;
					len_r_q <= head.length;
				end
				if (last) begin
					status_q <= status_c;
					largest_q <= '0;
					used_q <= 1'b0;
				end
			end
			S_APPLY: begin
				if (upd.valid) begin
					if (upd.is_free) begin
						if (upd.length > largest_q) largest_q <= upd.length;
					end else begin
						used_q <= 1'b1;
					end
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_q.status <= status_q;
					rsp_q.alloc_pos <= (ok && req_q.action == bfra_pkg::ACT_ALLOC)
						? best_start_q : '0;
					rsp_q.largest_free <= largest_q;
					rsp_q.has_allocations <= used_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/bfra_cell.sv
`default_nettype none
module bfra_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             shift,
	input  wire bfra_pkg::entry_t nxt,
	output bfra_pkg::entry_t      cur
);

	logic                            valid_q;
	logic [bfra_pkg::POS_BITS-1:0]   start_q;
	logic [bfra_pkg::POS_BITS-1:0]   length_q;
	logic                            is_free_q;
	logic [bfra_pkg::STAMP_BITS-1:0] stamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			start_q <= nxt.start;
			length_q <= nxt.length;
			is_free_q <= nxt.is_free;
			stamp_q <= nxt.stamp;
		end
	end

	assign cur = '{valid: valid_q, start: start_q, length: length_q,
		is_free: is_free_q, stamp: stamp_q};

endmodule
`default_nettype wire
